// File: rtl/jsu_pkg.sv
package jsu_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2
    } mode_t;

    // one burst of output bytes caused by a single input item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            str_end;
    } burst_t;

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_N)
            r = CH_LF;
        else if (c == CH_T)
            r = CH_TAB;
        else if (c == CH_R)
            r = CH_CR;
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] h);
        logic [3:0] r;
        r = 4'd0;
        if (h >= 8'h30 && h <= 8'h39)
            r = 4'(h - 8'h30);
        else if (h >= 8'h61 && h <= 8'h66)
            r = 4'(h - 8'h61 + 8'd10);
        else if (h >= 8'h41 && h <= 8'h46)
            r = 4'(h - 8'h41 + 8'd10);
        return r;
    endfunction

endpackage

// File: rtl/jsu_front.sv
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      in_byte,
    input  logic            in_end,
    output logic            rec_valid,
    output jsu_pkg::burst_t rec
);
    import jsu_pkg::*;

    mode_t           mode_reg, mode_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [15:0]     code_reg, code_next;
    logic [2:0][7:0] held_reg;
    logic            held_we;
    logic [15:0]     v;
    logic [2:0]      n;
    logic [3:0][7:0] res;

    assign v = {code_reg[11:0], hex_val(in_byte)};

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        code_next = code_reg;
        held_we   = 1'b0;
        n         = 3'd0;
        res       = '0;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (in_byte == CH_U && !in_end)
                begin
                    mode_next = MODE_HEX;
                    cnt_next  = 2'd0;
                    code_next = 16'd0;
                end
                else
                begin
                    res[0]    = esc_map(in_byte);
                    n         = 3'd1;
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_HEX:
            begin
                if (cnt_reg == 2'd3)
                begin
                    if (v < UTF8_ONE_LIMIT)
                    begin
                        res[0] = v[7:0];
                        n      = 3'd1;
                    end
                    else if (v < UTF8_TWO_LIMIT)
                    begin
                        res[0] = UTF8_LEAD2 | {3'd0, v[10:6]};
                        res[1] = UTF8_CONT | (v[7:0] & UTF8_CONT_MASK);
                        n      = 3'd2;
                    end
                    else
                    begin
                        res[0] = UTF8_LEAD3 | {4'd0, v[15:12]};
                        res[1] = UTF8_CONT | {2'd0, v[11:6]};
                        res[2] = UTF8_CONT | (v[7:0] & UTF8_CONT_MASK);
                        n      = 3'd3;
                    end
                    mode_next = MODE_PLAIN;
                    cnt_next  = 2'd0;
                    code_next = 16'd0;
                end
                else if (in_end)
                begin
                    // escape cut short: 'u' then held text replayed as plain text
                    res[0] = CH_U;
                    unique case (cnt_reg)
                        2'd0:
                        begin
                            res[1] = in_byte;
                            n      = 3'd2;
                        end
                        2'd1:
                        begin
                            if (held_reg[0] == CH_BSLASH)
                            begin
                                res[1] = esc_map(in_byte);
                                n      = 3'd2;
                            end
                            else
                            begin
                                res[1] = held_reg[0];
                                res[2] = in_byte;
                                n      = 3'd3;
                            end
                        end
                        default:
                        begin
                            if (held_reg[0] == CH_BSLASH)
                            begin
                                res[1] = esc_map(held_reg[1]);
                                res[2] = in_byte;
                                n      = 3'd3;
                            end
                            else if (held_reg[1] == CH_BSLASH)
                            begin
                                res[1] = held_reg[0];
                                res[2] = esc_map(in_byte);
                                n      = 3'd3;
                            end
                            else
                            begin
                                res[1] = held_reg[0];
                                res[2] = held_reg[1];
                                res[3] = in_byte;
                                n      = 3'd4;
                            end
                        end
                    endcase
                end
                else
                begin
                    held_we   = 1'b1;
                    code_next = v;
                    cnt_next  = 2'(cnt_reg + 2'd1);
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
                if (in_byte == CH_BSLASH && !in_end)
                    mode_next = MODE_ESC;
                else
                begin
                    res[0] = in_byte;
                    n      = 3'd1;
                end
            end
        endcase
        if (in_end)
        begin
            mode_next = MODE_PLAIN;
            cnt_next  = 2'd0;
            code_next = 16'd0;
        end
    end

    assign rec_valid    = take && (n != 3'd0);
    assign rec.bytes    = res;
    assign rec.last_idx = 2'(n - 3'd1);
    assign rec.str_end  = in_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            cnt_reg  <= 2'd0;
            code_reg <= 16'd0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            code_reg <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && held_we)
            held_reg[cnt_reg] <= in_byte;
    end

endmodule

// File: rtl/jsu_queue.sv
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  jsu_pkg::burst_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output jsu_pkg::burst_t rd_data,
    output logic            not_empty
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    burst_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : PW'(wr_ptr_reg + 1'b1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : PW'(rd_ptr_reg + 1'b1);
            if (do_wr && !do_rd)
                count_reg <= CW'(count_reg + 1'b1);
            else if (do_rd && !do_wr)
                count_reg <= CW'(count_reg - 1'b1);
        end
    end

endmodule

// File: rtl/jsu_back.sv
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  jsu_pkg::burst_t q_data,
    output logic            q_rd,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_end
);
    import jsu_pkg::*;

    burst_t     cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_last;
    logic       load;

    assign at_last    = (idx_reg == cur_reg.last_idx);
    assign empty      = !valid_reg;
    assign load       = !valid_reg || (pop && at_last);
    assign q_rd       = load && q_not_empty;
    assign out_byte   = cur_reg.bytes[idx_reg];
    assign run_last   = at_last;
    assign string_end = at_last && cur_reg.str_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= q_not_empty;
            idx_reg   <= 2'd0;
        end
        else if (pop)
            idx_reg <= 2'(idx_reg + 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_data;
    end

endmodule

// File: rtl/json_string_unescape_unit.sv
// Output path: with the back end idle, a result byte reaches the output ports once the queue
// has been written on taking its item and the back end register has then loaded it from there.
// Throughput: one item per cycle while the burst queue has room; while pop is held, output
// drains one byte per cycle, so items that expand to several bytes (UTF-8, cut-short
// escapes) fill the queue and full rises until the back end catches up.
// Reset: rst_n clears parser mode, hex counter, code, queue pointers and count, output valid and byte index.
module json_string_unescape_unit #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);
    import jsu_pkg::*;

    logic   q_full;
    logic   take;
    logic   rec_valid;
    burst_t rec;
    logic   q_rd;
    logic   q_not_empty;
    burst_t q_data;

    assign full = q_full;
    assign take = push && !q_full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .in_end    (in_end),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_valid),
        .wr_data   (rec),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_data   (q_data),
        .not_empty (q_not_empty)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_end  (string_end)
    );

endmodule
